/* hdl/stba_pkg.sv */
// stba_pkg: shared constants, operation and run-state codes, and the
// pipeline control struct of the suspendable timebase accumulator.
// No dependencies.
`timescale 1ns / 1ps

package stba_pkg;

   // Default microseconds per millisecond
   localparam int TICKS_PER_MS_DEF = 1000;

   // Operation codes carried in the mode field
   localparam logic [2:0] MODE_START   = 3'd0;
   localparam logic [2:0] MODE_NOW     = 3'd1;
   localparam logic [2:0] MODE_SUSPEND = 3'd2;
   localparam logic [2:0] MODE_RESUME  = 3'd3;
   localparam logic [2:0] MODE_STOP    = 3'd4;
   localparam logic [2:0] MODE_HEALTH  = 3'd5;

   // Run states
   localparam logic [1:0] ST_OFF       = 2'd0;
   localparam logic [1:0] ST_RUNNING   = 2'd1;
   localparam logic [1:0] ST_SUSPENDED = 2'd2;
   localparam logic [1:0] ST_FAULT     = 2'd3;

   // Per-transaction control that travels alongside the delta
   typedef struct packed {
      logic       ok;
      logic       add;
      logic       clear;
      logic [1:0] run_state;
   } ctrl_type;

endpackage

/* hdl/stba_req_if.sv */
// stba_req_if: request channel (valid/ready plus operation payload).
// Depends on nothing.
`timescale 1ns / 1ps

interface stba_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [31:0] counter_value;
   logic [31:0] sleep_us;
   logic        timer_intact;
   logic        caller_ok;

   modport source (output valid, mode, counter_value, sleep_us, timer_intact,
                   caller_ok, input ready);
   modport sink   (input valid, mode, counter_value, sleep_us, timer_intact,
                   caller_ok, output ready);
endinterface

/* hdl/stba_rsp_if.sv */
// stba_rsp_if: response channel (valid/ready plus status and totals).
// Depends on nothing.
`timescale 1ns / 1ps

interface stba_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [31:0] time_us;
   logic [31:0] time_ms;
   logic [1:0]  run_state;

   modport source (output valid, ok, time_us, time_ms, run_state, input ready);
   modport sink   (input valid, ok, time_us, time_ms, run_state, output ready);
endinterface

/* hdl/suspendable_timebase_accumulator.sv */
// suspendable_timebase_accumulator: top level, run-state control, total
// accumulation and response register. Uses stba_pkg, stba_req_if,
// stba_rsp_if and stba_ms_split.
`timescale 1ns / 1ps

// Timebase keeper with off/running/suspended/fault states. Each request
// transaction carries an operation and a sampled free-running microsecond
// count; each produces exactly one response with the status, the wrapping
// microsecond and millisecond totals and the run state after the operation.
// One transaction is accepted per clock unless the pipeline is stalled.
// Five register stages sit between request and response: the control
// stage, three stages of the millisecond split (reciprocal multiply,
// remainder estimate, correction) and the accumulate/response register.
// Run state and last sample update at acceptance, so back-to-back
// operations see each other immediately; the totals update in order at
// the last stage. Backpressure on the response side stalls the pipeline
// stage by stage, so requests are still taken while bubbles remain.
module suspendable_timebase_accumulator
   import stba_pkg::*;
#(
   parameter int TICKS_PER_MS = TICKS_PER_MS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   stba_req_if.sink    req_if,
   stba_rsp_if.source  rsp_if
);

   localparam int RemW = $clog2(TICKS_PER_MS);
   localparam logic [RemW:0] TicksW = (RemW+1)'(TICKS_PER_MS);

   // architectural state
   logic [1:0]      run_mode_ff, run_mode_in;
   logic [31:0]     last_count_ff, last_count_in;
   logic [RemW-1:0] sub_ms_ff, sub_ms_in;
   logic [31:0]     micros_ff, micros_in;
   logic [31:0]     millis_ff, millis_in;

   // control stage register
   logic            s1_valid_ff;
   logic [31:0]     s1_delta_ff, s1_delta_in;
   ctrl_type        s1_ctrl_ff, s1_ctrl_in;
   logic            s1_ready;
   logic            req_take;

   // split pipeline outputs
   logic            sp_in_ready;
   logic            sp_valid;
   logic [31:0]     sp_delta;
   ctrl_type        sp_ctrl;
   logic [31:0]     sp_quot;
   logic [RemW-1:0] sp_rem;

   // response register
   logic            rsp_valid_ff;
   logic            rsp_ok_ff;
   logic [1:0]      rsp_state_ff;
   logic            out_ready;
   logic            out_load;

   logic [RemW:0]   rem_sum;
   logic            carry;

   assign s1_ready     = !s1_valid_ff || sp_in_ready;
   assign req_if.ready = s1_ready;
   assign req_take     = req_if.valid && s1_ready;

   // Operation decode against the current run state
   always_comb begin
      run_mode_in   = run_mode_ff;
      last_count_in = last_count_ff;
      s1_delta_in   = 32'd0;
      s1_ctrl_in    = '0;
      case (req_if.mode)
         MODE_START: begin
            if (req_if.caller_ok && run_mode_ff == ST_OFF && req_if.timer_intact) begin
               s1_ctrl_in.clear = 1'b1;
               s1_ctrl_in.ok    = 1'b1;
               last_count_in    = 32'd0;
               run_mode_in      = ST_RUNNING;
            end
         end
         MODE_NOW, MODE_SUSPEND: begin
            if (req_if.caller_ok && run_mode_ff == ST_RUNNING) begin
               if (req_if.timer_intact) begin
                  s1_ctrl_in.add = 1'b1;
                  s1_ctrl_in.ok  = 1'b1;
                  s1_delta_in    = req_if.counter_value - last_count_ff;
                  last_count_in  = req_if.counter_value;
                  if (req_if.mode == MODE_SUSPEND) run_mode_in = ST_SUSPENDED;
               end else begin
                  run_mode_in = ST_FAULT;
               end
            end
         end
         MODE_RESUME: begin
            if (req_if.caller_ok && run_mode_ff == ST_SUSPENDED) begin
               // counter must not have moved while suspended
               if (req_if.timer_intact && req_if.counter_value == last_count_ff) begin
                  s1_ctrl_in.add = 1'b1;
                  s1_ctrl_in.ok  = 1'b1;
                  s1_delta_in    = req_if.sleep_us;
                  run_mode_in    = ST_RUNNING;
               end else begin
                  run_mode_in = ST_FAULT;
               end
            end
         end
         MODE_STOP: begin
            if (req_if.caller_ok && run_mode_ff != ST_OFF) begin
               run_mode_in   = ST_OFF;
               s1_ctrl_in.ok = 1'b1;
            end
         end
         MODE_HEALTH: begin
            s1_ctrl_in.ok = (run_mode_ff == ST_RUNNING) || (run_mode_ff == ST_SUSPENDED);
         end
         default: begin
            // unused codes: rejected, no change
         end
      endcase
      s1_ctrl_in.run_state = run_mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff   <= ST_OFF;
         last_count_ff <= 32'd0;
         s1_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            run_mode_ff   <= run_mode_in;
            last_count_ff <= last_count_in;
         end
         if (s1_ready) s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_delta_ff <= s1_delta_in;
         s1_ctrl_ff  <= s1_ctrl_in;
      end
   end

   stba_ms_split #(
      .TICKS_PER_MS (TICKS_PER_MS)
   ) u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (sp_in_ready),
      .in_delta  (s1_delta_ff),
      .in_ctrl   (s1_ctrl_ff),
      .out_valid (sp_valid),
      .out_ready (out_ready),
      .out_delta (sp_delta),
      .out_ctrl  (sp_ctrl),
      .out_quot  (sp_quot),
      .out_rem   (sp_rem)
   );

   assign out_ready = !rsp_valid_ff || rsp_if.ready;
   assign out_load  = sp_valid && out_ready;

   // Fold the remainder into the carried fraction; at most one extra ms
   assign rem_sum = {1'b0, sub_ms_ff} + {1'b0, sp_rem};
   assign carry   = rem_sum >= TicksW;

   always_comb begin
      sub_ms_in = sub_ms_ff;
      micros_in = micros_ff;
      millis_in = millis_ff;
      if (sp_ctrl.clear) begin
         sub_ms_in = '0;
         micros_in = 32'd0;
         millis_in = 32'd0;
      end else if (sp_ctrl.add) begin
         sub_ms_in = carry ? RemW'(rem_sum - TicksW) : RemW'(rem_sum);
         micros_in = micros_ff + sp_delta;
         millis_in = millis_ff + sp_quot + 32'(carry);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ms_ff    <= '0;
         micros_ff    <= 32'd0;
         millis_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            sub_ms_ff <= sub_ms_in;
            micros_ff <= micros_in;
            millis_ff <= millis_in;
         end
         if (out_ready) rsp_valid_ff <= sp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ok_ff    <= sp_ctrl.ok;
         rsp_state_ff <= sp_ctrl.run_state;
      end
   end

   // totals registers double as the response payload
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.ok        = rsp_ok_ff;
   assign rsp_if.time_us   = micros_ff;
   assign rsp_if.time_ms   = millis_ff;
   assign rsp_if.run_state = rsp_state_ff;

endmodule

/* hdl/stba_ms_split.sv */
// stba_ms_split: three-stage pipeline that splits a 32-bit delta into whole
// milliseconds and a sub-millisecond remainder. Uses stba_pkg.
`timescale 1ns / 1ps

module stba_ms_split
   import stba_pkg::*;
#(
   parameter int TICKS_PER_MS = TICKS_PER_MS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [31:0]                      in_delta,
   input  ctrl_type                         in_ctrl,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [31:0]                      out_delta,
   output ctrl_type                         out_ctrl,
   output logic [31:0]                      out_quot,
   output logic [$clog2(TICKS_PER_MS)-1:0] out_rem
);

   localparam int RemW = $clog2(TICKS_PER_MS);
   // floor(2^32 / ticks): estimate is exact or one low
   localparam logic [63:0] RecipWide = (64'd1 << 32) / 64'(TICKS_PER_MS);
   localparam logic [31:0] Recip     = RecipWide[31:0];
   localparam logic [RemW:0] TicksW  = (RemW+1)'(TICKS_PER_MS);

   logic            va_ff, vb_ff, vc_ff;
   logic            ready_a, ready_b, ready_c;
   logic [31:0]     delta_a_ff, delta_b_ff, delta_c_ff;
   ctrl_type        ctrl_a_ff, ctrl_b_ff, ctrl_c_ff;
   logic [31:0]     qest_a_ff, qest_b_ff, quot_c_ff;
   logic [RemW:0]   rraw_b_ff;
   logic [RemW-1:0] rem_c_ff;

   logic [31:0]     qest_in;
   logic [RemW:0]   qd_low;
   logic [RemW:0]   rraw_in;
   logic            over;

   assign ready_c  = !vc_ff || out_ready;
   assign ready_b  = !vb_ff || ready_c;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;

   // stage a: reciprocal multiply
   assign qest_in = 32'((64'(in_delta) * 64'(Recip)) >> 32);
   // stage b: remainder estimate, low bits suffice (below twice ticks)
   assign qd_low  = (RemW+1)'(qest_a_ff * 32'(TICKS_PER_MS));
   assign rraw_in = delta_a_ff[RemW:0] - qd_low;
   // stage c: one correction step
   assign over    = rraw_b_ff >= TicksW;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ready_a) va_ff <= in_valid;
         if (ready_b) vb_ff <= va_ff;
         if (ready_c) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         delta_a_ff <= in_delta;
         ctrl_a_ff  <= in_ctrl;
         qest_a_ff  <= qest_in;
      end
      if (ready_b) begin
         delta_b_ff <= delta_a_ff;
         ctrl_b_ff  <= ctrl_a_ff;
         qest_b_ff  <= qest_a_ff;
         rraw_b_ff  <= rraw_in;
      end
      if (ready_c) begin
         delta_c_ff <= delta_b_ff;
         ctrl_c_ff  <= ctrl_b_ff;
         quot_c_ff  <= qest_b_ff + 32'(over);
         rem_c_ff   <= over ? RemW'(rraw_b_ff - TicksW) : RemW'(rraw_b_ff);
      end
   end

   assign out_valid = vc_ff;
   assign out_delta = delta_c_ff;
   assign out_ctrl  = ctrl_c_ff;
   assign out_quot  = quot_c_ff;
   assign out_rem   = rem_c_ff;

endmodule

/* tb/stba_tb_pkg.sv */
// stba_tb_pkg: transaction types and the timebase tracker class, which predicts
// and checks the responses of the suspendable timebase accumulator.
// Depends on stba_pkg.
`timescale 1ns / 1ps

package stba_tb_pkg;
   import stba_pkg::*;

   // Mode codes with no operation behind them
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   localparam int unsigned US_PER_MS = TICKS_PER_MS_DEF;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] count;
      logic [31:0] elapsed;
      logic        intact;
      logic        caller;
   } timebase_op_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] us;
      logic [31:0] ms;
      logic [1:0]  state;
   } timebase_status_type;

   class timebase_tracker;
      logic [1:0]          state_now;
      logic [31:0]         last_sample;
      int unsigned         frac_us;
      logic [31:0]         total_us;
      logic [31:0]         total_ms;
      timebase_status_type expected_status[$];
      int unsigned         mismatches;

      function new();
         state_now   = ST_OFF;
         last_sample = '0;
         frac_us     = 0;
         total_us    = '0;
         total_ms    = '0;
         mismatches  = 0;
      endfunction

      // Split the span into whole ms and a carried sub-ms remainder
      function void add_time(logic [31:0] span);
         total_us += span;
         total_ms += span / US_PER_MS;
         frac_us  += span % US_PER_MS;
         total_ms += frac_us / US_PER_MS;
         frac_us   = frac_us % US_PER_MS;
      endfunction

      // Applies one accepted request transaction and queues its status
      function void note_op(timebase_op_type op);
         logic                ok;
         timebase_status_type st;
         ok = 1'b0;
         case (op.mode)
            MODE_START: begin
               if (op.caller && state_now == ST_OFF && op.intact) begin
                  total_us    = '0;
                  total_ms    = '0;
                  frac_us     = 0;
                  last_sample = '0;
                  state_now   = ST_RUNNING;
                  ok          = 1'b1;
               end
            end
            MODE_NOW, MODE_SUSPEND: begin
               if (op.caller && state_now == ST_RUNNING) begin
                  if (op.intact) begin
                     add_time(op.count - last_sample);
                     last_sample = op.count;
                     if (op.mode == MODE_SUSPEND) state_now = ST_SUSPENDED;
                     ok = 1'b1;
                  end else begin
                     state_now = ST_FAULT;
                  end
               end
            end
            MODE_RESUME: begin
               if (op.caller && state_now == ST_SUSPENDED) begin
                  if (op.intact && op.count == last_sample) begin
                     add_time(op.elapsed);
                     state_now = ST_RUNNING;
                     ok        = 1'b1;
                  end else begin
                     state_now = ST_FAULT;
                  end
               end
            end
            MODE_STOP: begin
               if (op.caller && state_now != ST_OFF) begin
                  state_now = ST_OFF;
                  ok        = 1'b1;
               end
            end
            MODE_HEALTH: begin
               ok = (state_now == ST_RUNNING || state_now == ST_SUSPENDED);
            end
            default: ;
         endcase
         st.ok    = ok;
         st.us    = total_us;
         st.ms    = total_ms;
         st.state = state_now;
         expected_status.push_back(st);
      endfunction

      function void check_status(timebase_status_type got);
         timebase_status_type want;
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: ok=%0b us=%h ms=%h state=%0d",
                        got.ok, got.us, got.ms, got.state);
            return;
         end
         want = expected_status.pop_front();
         if (got.ok !== want.ok || got.us !== want.us || got.ms !== want.ms ||
             got.state !== want.state) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp ok=%0b us=%h ms=%h st=%0d, got ok=%0b us=%h ms=%h st=%0d",
                        want.ok, want.us, want.ms, want.state,
                        got.ok, got.us, got.ms, got.state);
         end
      endfunction

      function int unsigned outstanding();
         return expected_status.size();
      endfunction
   endclass

endpackage

/* tb/suspendable_timebase_accumulator_tb.sv */
// suspendable_timebase_accumulator_tb: top-level testbench. Drives request
// transactions, stalls the response side and checks every response.
// Depends on stba_pkg, stba_tb_pkg, stba_req_if, stba_rsp_if and the block.
`timescale 1ns / 1ps

module suspendable_timebase_accumulator_tb;
   import stba_pkg::*;
   import stba_tb_pkg::*;

   // Cycles with no transaction on either channel before giving up
   localparam int unsigned QUIET_LIMIT = 4000;
   // Random items per idling phase (three phases)
   localparam int unsigned ITEMS_PER_PHASE = 400;
   // Pipeline is 5 deep; settle margin after the last response
   localparam int unsigned SETTLE_CYCLES = 20;

   logic clock;
   logic reset;

   stba_req_if req_bus ();
   stba_rsp_if rsp_bus ();

   suspendable_timebase_accumulator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   timebase_tracker tracker;

   // Idle percentages of the current phase, per side
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned quiet_cycles;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Response side: ready toggles at random at the falling edge
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Response monitor: sampled at the rising edge, checked against the oldest
   // prediction
   always @(posedge clock) begin : rsp_monitor
      timebase_status_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.ok    = rsp_bus.ok;
         got.us    = rsp_bus.time_us;
         got.ms    = rsp_bus.time_ms;
         got.state = rsp_bus.run_state;
         tracker.check_status(got);
      end
   end

   // Watchdog: any transaction on either side resets the count
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[suspendable_timebase_accumulator] ERROR");
         $finish;
      end
   end

   // Presents one request transaction and returns once it is accepted. Starts
   // just after a rising edge; valid only changes at falling edges, and at most
   // once per edge, so back-to-back transactions keep valid high.
   task automatic send_op(input timebase_op_type op);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= op.mode;
      req_bus.counter_value <= op.count;
      req_bus.sleep_us      <= op.elapsed;
      req_bus.timer_intact  <= op.intact;
      req_bus.caller_ok     <= op.caller;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      // State moves at acceptance, so the tracker is current for the next pick
      tracker.note_op(op);
   endtask

   task automatic send_fields(input logic [2:0] mode, input logic [31:0] count,
                              input logic [31:0] elapsed, input logic intact,
                              input logic caller);
      timebase_op_type op;
      op.mode    = mode;
      op.count   = count;
      op.elapsed = elapsed;
      op.intact  = intact;
      op.caller  = caller;
      send_op(op);
   endtask

   // Time span: mostly short, some up to a second, a few across the full range
   function automatic logic [31:0] pick_span();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return $urandom_range(2999);
      if (roll < 85) return $urandom_range(1000000);
      return $urandom;
   endfunction

   // Random request shaped by the predicted run state: mostly well-formed
   // lifecycles (start, samples, suspend/resume with a frozen counter, stop),
   // with rare check failures and about one transaction in seven pure noise.
   function automatic timebase_op_type pick_op();
      timebase_op_type op;
      int unsigned     roll;
      op.count   = $urandom;
      op.elapsed = ($urandom_range(1)) ? pick_span() : $urandom;
      op.intact  = ($urandom_range(99) >= 4);
      op.caller  = ($urandom_range(99) >= 4);
      roll       = $urandom_range(99);
      if (roll < 15) begin
         op.mode   = 3'($urandom_range(7));
         op.intact = 1'($urandom_range(1));
         op.caller = 1'($urandom_range(1));
         return op;
      end
      case (tracker.state_now)
         ST_OFF: begin
            op.mode = (roll < 95) ? MODE_START : MODE_HEALTH;
         end
         ST_RUNNING: begin
            op.count = tracker.last_sample + pick_span();
            if (roll < 60)      op.mode = MODE_NOW;
            else if (roll < 85) op.mode = MODE_SUSPEND;
            else if (roll < 92) op.mode = MODE_HEALTH;
            else                op.mode = MODE_STOP;
         end
         ST_SUSPENDED: begin
            if (roll < 80) begin
               op.mode  = MODE_RESUME;
               op.count = tracker.last_sample;
            end else if (roll < 85) begin
               // counter moved while suspended
               op.mode  = MODE_RESUME;
               op.count = tracker.last_sample + pick_span();
            end else if (roll < 93) begin
               op.mode = MODE_HEALTH;
            end else begin
               op.mode = MODE_STOP;
            end
         end
         default: begin
            op.mode = (roll < 90) ? MODE_STOP : MODE_HEALTH;
         end
      endcase
      return op;
   endfunction

   initial begin
      tracker               = new();
      sender_idle_pct       = 31;
      receiver_idle_pct     = 58;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_HEALTH;
      req_bus.counter_value = '0;
      req_bus.sleep_us      = '0;
      req_bus.timer_intact  = 1'b0;
      req_bus.caller_ok     = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: each operation, rejection paths and the edge cases
      send_fields(MODE_HEALTH,  32'h0,        32'h0,        1'b0, 1'b0); // query while off
      send_fields(MODE_NOW,     32'd10,       32'h0,        1'b1, 1'b1); // sample while off
      send_fields(MODE_START,   32'h0,        32'h0,        1'b1, 1'b0); // bad caller
      send_fields(MODE_START,   32'h0,        32'h0,        1'b0, 1'b1); // timer check fails
      send_fields(MODE_START,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
      send_fields(MODE_START,   32'h0,        32'h0,        1'b1, 1'b1); // already running
      send_fields(MODE_NOW,     32'd999,      32'h0,        1'b1, 1'b1);
      send_fields(MODE_NOW,     32'd1998,     32'h0,        1'b1, 1'b1); // sub-ms carry
      send_fields(MODE_NOW,     32'd5000,     32'h0,        1'b1, 1'b0); // bad caller
      send_fields(MODE_NOW,     32'hFFFFFFFF, 32'h0,        1'b1, 1'b1);
      send_fields(MODE_NOW,     32'd5,        32'h0,        1'b1, 1'b1); // counter wraps
      send_fields(MODE_SUSPEND, 32'd1000,     32'h0,        1'b1, 1'b1);
      send_fields(MODE_NOW,     32'd2000,     32'h0,        1'b1, 1'b1); // sample while suspended
      send_fields(MODE_RESUME,  32'd1001,     32'd500,      1'b1, 1'b1); // counter moved: fault
      send_fields(MODE_HEALTH,  32'h0,        32'h0,        1'b1, 1'b1); // query in fault
      send_fields(MODE_STOP,    32'h0,        32'h0,        1'b1, 1'b0); // bad caller
      send_fields(MODE_STOP,    32'h0,        32'h0,        1'b0, 1'b1); // stop out of fault
      send_fields(MODE_START,   32'h0,        32'h0,        1'b1, 1'b1);
      send_fields(MODE_SUSPEND, 32'h80000000, 32'h0,        1'b1, 1'b1);
      send_fields(MODE_RESUME,  32'h80000000, 32'hFFFFFFFF, 1'b1, 1'b1); // largest elapsed
      send_fields(MODE_NOW,     32'h80000010, 32'h0,        1'b0, 1'b1); // timer check: fault
      send_fields(MODE_SPARE_6, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
      send_fields(MODE_SPARE_7, 32'h0,        32'h0,        1'b0, 1'b0);
      send_fields(MODE_STOP,    32'h0,        32'h0,        1'b1, 1'b1);
      send_fields(MODE_RESUME,  32'h0,        32'h0,        1'b1, 1'b1); // resume while off

      // Random: sender idles less than the receiver, then the reverse, then
      // both sides at full rate
      for (int unsigned phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 31;
               receiver_idle_pct = 58;
            end
            1: begin
               sender_idle_pct   = 58;
               receiver_idle_pct = 31;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) send_op(pick_op());
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Drain; the watchdog catches a response that never shows up
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("[suspendable_timebase_accumulator] OK");
      else
         $display("[suspendable_timebase_accumulator] ERROR");
      $finish;
   end

endmodule
